>>> rtl/core/crc32_forge_patch_defines.svh
// Assertion macros for the CRC-32 forge patch block.
`ifndef CRC32_FORGE_PATCH_DEFINES_SVH
`define CRC32_FORGE_PATCH_DEFINES_SVH

// Checked only while out of reset.
`define CFP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Checked at every edge, reset included.
`define CFP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> rtl/core/cfp_pkg.sv
// ---------------------------------------------------------------------------
// cfp_pkg
// Constants and CRC-32 step functions for the forge patch block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

  localparam int unsigned CRC_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_BYTES = CRC_W / BYTE_W;

  localparam logic [CRC_W-1:0] CRC_PRESET    = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_POLY_BACK = 32'hDB71_0641;
  localparam logic [CRC_W-1:0] TARGET_RESET  = 32'hFEEF_B9EB;

  // One forward byte step of the reflected CRC.
  function automatic logic [CRC_W-1:0] crc_fwd_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // One backward byte step: undo eight shifts, then inject a byte.
  function automatic logic [CRC_W-1:0] crc_back_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY_BACK) : (c << 1);
    end
    return c ^ {{(CRC_W-BYTE_W){1'b0}}, data};
  endfunction

  // Four backward steps from the target, high byte of the forward state first.
  function automatic logic [CRC_W-1:0] crc_forge(input logic [CRC_W-1:0] target,
                                                 input logic [CRC_W-1:0] fwd);
    logic [CRC_W-1:0] b;
    b = target ^ CRC_PRESET;
    for (int i = CRC_BYTES - 1; i >= 0; i--) begin
      b = crc_back_byte(b, fwd[i*BYTE_W +: BYTE_W]);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/crc32_forge_patch.sv
// ---------------------------------------------------------------------------
// crc32_forge_patch
// Running CRC-32 over a byte stream; emits a 4-byte patch forcing a target.
// ---------------------------------------------------------------------------
// Input channel: one message byte per beat (in_data_byte), in_last_byte marks
// the final byte. Output channel: one beat per message, out_patch_word, whose
// low byte is appended first so the patched message hits the target CRC.
// cfg_wr_en/cfg_wr_data load the target CRC; write only while idle.
// Throughput: one byte per cycle while in_stall is low. Each beat is held in
// the input register, then the CRC step (and on a last byte the four backward
// steps) runs in one pass into the result register.
// Result: once the last byte is in the input register and the result register
// is free, the patch word is registered and out_valid rises.
// Reset: running CRC preset to all ones, target to 0xFEEFB9EB, no beats held.
// Stall: while a result waits, non-last bytes keep flowing; a last byte
// waits in the input register and in_stall rises until the result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc32_forge_patch
  import cfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CRC_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CRC_W-1:0]       out_patch_word
);

  logic [CRC_W-1:0]  target_r;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic              a_valid_r;
  logic [BYTE_W-1:0] a_byte_r;
  logic              a_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0]  patch_r;
  logic [CRC_W-1:0]  crc_step;
  logic              out_free, a_adv, in_acc, res_load;

  assign out_free = !out_valid_r || !out_stall;
  assign a_adv    = a_valid_r && (!a_last_r || out_free);
  assign in_stall = a_valid_r && !a_adv;
  assign in_acc   = in_valid && !in_stall;
  assign res_load = a_adv && a_last_r;

  assign crc_step = crc_fwd_byte(crc_r, a_byte_r);

  always_comb begin
    crc_nxt = crc_r;
    if (a_adv) begin
      crc_nxt = a_last_r ? CRC_PRESET : crc_step;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RESET;
      crc_r       <= CRC_PRESET;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      crc_r       <= crc_nxt;
      a_valid_r   <= in_acc || (a_valid_r && !a_adv);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_byte_r <= in_data_byte;
      a_last_r <= in_last_byte;
    end
    if (res_load) begin
      patch_r <= crc_forge(target_r, crc_step);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_patch_word = patch_r;

endmodule

`default_nettype wire

>>> rtl/core/cfp_checker.sv
// ---------------------------------------------------------------------------
// cfp_checker
// Port-level checks for the CRC-32 forge patch block, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "crc32_forge_patch_defines.svh"

module cfp_checker
  import cfp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              in_last_byte,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [CRC_W-1:0]  out_patch_word
);

  logic last_acc;
  assign last_acc = in_valid && !in_stall && in_last_byte;

  `CFP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result beat after reset")
  `CFP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_patch_word), "stalled result beat dropped or changed")
  `CFP_ASSERT(a_last_emits, clk, rst_n, last_acc ##1 !out_valid |=> out_valid, "last byte gave no result beat")
  `CFP_ASSERT(a_last_blocks, clk, rst_n, last_acc ##1 (out_valid && out_stall) |-> in_stall, "pending last byte not held back")

endmodule

bind crc32_forge_patch cfp_checker u_cfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_byte   (in_last_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_patch_word (out_patch_word)
);

`default_nettype wire

>>> test/cfp_patch_scoreboard.sv
// ---------------------------------------------------------------------------
// cfp_patch_scoreboard
// Watches the byte and patch channels, predicts each patch word and compares.
// ---------------------------------------------------------------------------
// Keeps its own running CRC-32 and target copy. Every accepted byte beat is
// folded in bit-serially. A last byte unwinds the target four bytes back
// through the forward state to give the expected patch word, queues it, then
// presets the CRC. Accepted result beats are checked in order against the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_patch_scoreboard
  import cfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CRC_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CRC_W-1:0]  out_patch_word,
  output int                err_count,
  output int                pending
);

  localparam int REPORT_LIMIT = 10;

  logic [CRC_W-1:0] crc_acc;
  logic [CRC_W-1:0] target_crc;
  logic [CRC_W-1:0] patch_fifo [$];
  int               errs = 0;

  function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] r;
    r = crc ^ CRC_W'(data);
    repeat (BYTE_W) r = (r >> 1) ^ (CRC_POLY & {CRC_W{r[0]}});
    return r;
  endfunction

  // Inverse of eight forward shifts: a set top bit means the poly was folded in.
  function automatic logic [CRC_W-1:0] crc_unfold_shifts(input logic [CRC_W-1:0] crc);
    logic [CRC_W-1:0] r;
    r = crc;
    repeat (BYTE_W) r = r[CRC_W-1] ? (((r ^ CRC_POLY) << 1) | CRC_W'(1)) : (r << 1);
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] forge_patch_word(input logic [CRC_W-1:0] target,
                                                        input logic [CRC_W-1:0] fwd);
    logic [CRC_W-1:0] b;
    b = target ^ CRC_PRESET;
    for (int i = CRC_BYTES - 1; i >= 0; i--) begin
      b = crc_unfold_shifts(b) ^ CRC_W'(fwd[i*BYTE_W +: BYTE_W]);
    end
    return b;
  endfunction

  always @(posedge clk) begin : track
    logic [CRC_W-1:0] want;
    if (!rst_n) begin
      crc_acc    = CRC_PRESET;
      target_crc = TARGET_RESET;
      patch_fifo.delete();
    end else begin
      if (cfg_wr_en) begin
        target_crc = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (patch_fifo.size() == 0) begin
          if (errs < REPORT_LIMIT) begin
            $display("unexpected patch beat: got %h", out_patch_word);
          end
          errs++;
        end else begin
          want = patch_fifo.pop_front();
          if (out_patch_word !== want) begin
            if (errs < REPORT_LIMIT) begin
              $display("patch_word mismatch: expected %h, got %h", want, out_patch_word);
            end
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        crc_acc = crc_fold_byte(crc_acc, in_data_byte);
        if (in_last_byte) begin
          patch_fifo.push_back(forge_patch_word(target_crc, crc_acc));
          crc_acc = CRC_PRESET;
        end
      end
    end
    err_count <= errs;
    pending   <= patch_fifo.size();
  end

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the CRC-32 forge patch block.
// ---------------------------------------------------------------------------
// Sends directed messages (single bytes, all-ones, check string), then random
// messages under several target CRCs, extremes included. Both channels idle
// at random; one phase holds the result side off long enough to back up the
// input. The scoreboard beside the block does all prediction and patch checking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cfp_pkg::*;

  localparam int WDOG_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BEATS  = 200;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_PHASE   = 5;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CRC_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CRC_W-1:0]  out_patch_word;

  int patch_errors;
  int patches_pending;
  int beats_sent = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit long_hold = 1'b0;

  crc32_forge_patch u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_patch_word(out_patch_word)
  );

  cfp_patch_scoreboard u_sb (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_patch_word(out_patch_word),
    .err_count     (patch_errors),
    .pending       (patches_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_beat(input logic [BYTE_W-1:0] data, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    beats_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_message(input int max_len);
    int len;
    if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      send_beat(pick_byte(), i == len - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (patches_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [CRC_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CRC_W-1:0] phase_target(input int phase);
    case (phase)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hCBF4_3926;
      4:       return 32'h8000_0001;
      7:       return TARGET_RESET;
      default: return CRC_W'($urandom());
    endcase
  endfunction

  // result side: random stall per beat, one long hold on request
  initial begin : sink
    int n;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        n = rx_burst ? 0 : $urandom_range(0, 4);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset target
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    for (int i = 0; i < 9; i++) send_beat(BYTE_W'(8'h31 + i), i == 8);
    for (int i = 0; i < 4; i++) send_beat(8'hFF, i == 3);
    send_beat(8'h01, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_target(phase_target(p));
      if (p == HOLD_PHASE) long_hold = 1'b1;
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        random_message((p == HOLD_PHASE) ? 2 : 6);
      end
    end

    settle();
    if (patch_errors == 0 && patches_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
